>>> rtl/sfcp_pkg.sv
package sfcp_pkg;

    localparam int ADDR_W = 24;
    localparam int KIND_W = 3;
    localparam int LEN_W = 16;
    localparam int OPCODE_W = 8;
    localparam int DIR_W = 2;

    localparam int PAGE_BYTES_DEF = 256;
    localparam int MAX_WRITE_BYTES_DEF = 4096;

    localparam int MAX_RESULTS = 34;
    localparam int MAX_CHUNKS = MAX_RESULTS / 2;
    localparam int CNT_W = $clog2(MAX_CHUNKS);

    localparam logic [KIND_W-1:0] KIND_READ = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SECTOR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BLOCK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHIP = 3'd4;

    localparam logic [OPCODE_W-1:0] OP_WREN = 8'h06;
    localparam logic [OPCODE_W-1:0] OP_PROGRAM = 8'h02;
    localparam logic [OPCODE_W-1:0] OP_READ = 8'h03;
    localparam logic [OPCODE_W-1:0] OP_SECTOR = 8'h20;
    localparam logic [OPCODE_W-1:0] OP_BLOCK = 8'hD8;
    localparam logic [OPCODE_W-1:0] OP_CHIP = 8'hC7;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_SEND = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RECV = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_EWREN = 7'b0000100,
        S_ERASE = 7'b0001000,
        S_REM   = 7'b0010000,
        S_WREN  = 7'b0100000,
        S_PROG  = 7'b1000000
    } state_t;

endpackage

>>> rtl/sfcp_req_if.sv
interface sfcp_req_if;
    logic                            valid;
    logic                            ready;
    logic [sfcp_pkg::KIND_W-1:0]     kind;
    logic [sfcp_pkg::ADDR_W-1:0]     address;
    logic [sfcp_pkg::LEN_W-1:0]      length;

    modport source (output valid, output kind, output address, output length, input ready);
    modport sink (input valid, input kind, input address, input length, output ready);
endinterface

>>> rtl/sfcp_txn_if.sv
interface sfcp_txn_if;
    logic                            valid;
    logic                            ready;
    logic [sfcp_pkg::OPCODE_W-1:0]   opcode;
    logic [sfcp_pkg::ADDR_W-1:0]     flash_address;
    logic                            has_address;
    logic [sfcp_pkg::DIR_W-1:0]      data_dir;
    logic [sfcp_pkg::LEN_W-1:0]      data_count;
    logic                            poll_after;
    logic                            clamped;
    logic                            last;

    modport source (output valid, output opcode, output flash_address, output has_address,
                    output data_dir, output data_count, output poll_after, output clamped,
                    output last, input ready);
    modport sink (input valid, input opcode, input flash_address, input has_address,
                  input data_dir, input data_count, input poll_after, input clamped,
                  input last, output ready);
endinterface

>>> rtl/sfcp_rem_unit.sv
module sfcp_rem_unit #(
    parameter int PAGE_BYTES = sfcp_pkg::PAGE_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [sfcp_pkg::ADDR_W-1:0]         dividend,
    output logic                                busy,
    output logic [$clog2(PAGE_BYTES)-1:0]       rem
);

    localparam int REM_W = $clog2(PAGE_BYTES);
    localparam int TRIAL_W = REM_W + 1;
    localparam int RECIP = (1 << sfcp_pkg::ADDR_W) / PAGE_BYTES;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W = sfcp_pkg::ADDR_W + RECIP_W;

    localparam logic [1:0] STEP_QUOT = 2'd0;
    localparam logic [1:0] STEP_TRIAL = 2'd1;
    localparam logic [1:0] STEP_FIX = 2'd2;

    logic                              busy_reg;
    logic                              busy_next;
    logic [1:0]                        step_reg;
    logic [1:0]                        step_next;
    logic [sfcp_pkg::ADDR_W-1:0]       dvd_reg;
    logic [sfcp_pkg::ADDR_W-1:0]       dvd_next;
    logic [RECIP_W-1:0]                quot_reg;
    logic [RECIP_W-1:0]                quot_next;
    logic [TRIAL_W-1:0]                trial_reg;
    logic [TRIAL_W-1:0]                trial_next;
    logic [REM_W-1:0]                  rem_reg;
    logic [REM_W-1:0]                  rem_next;
    logic [PROD_W-1:0]                 product;
    logic [TRIAL_W-1:0]                multiple;

    // The reciprocal estimate of the quotient is low by at most one, so the
    // trial remainder is below twice the page size and one subtraction fixes it.
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        dvd_next = dvd_reg;
        quot_next = quot_reg;
        trial_next = trial_reg;
        rem_next = rem_reg;
        product = PROD_W'(dvd_reg) * PROD_W'(RECIP);
        multiple = quot_reg[TRIAL_W-1:0] * TRIAL_W'(PAGE_BYTES);
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_QUOT;
            dvd_next = dividend;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                STEP_QUOT:
                begin
                    quot_next = product[PROD_W-1:sfcp_pkg::ADDR_W];
                    step_next = STEP_TRIAL;
                end
                STEP_TRIAL:
                begin
                    trial_next = dvd_reg[TRIAL_W-1:0] - multiple;
                    step_next = STEP_FIX;
                end
                STEP_FIX:
                begin
                    if (trial_reg >= TRIAL_W'(PAGE_BYTES))
                    begin
                        rem_next = REM_W'(trial_reg - TRIAL_W'(PAGE_BYTES));
                    end
                    else
                    begin
                        rem_next = trial_reg[REM_W-1:0];
                    end
                    busy_next = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_QUOT;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quot_reg <= quot_next;
        trial_reg <= trial_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem = rem_reg;

endmodule

>>> rtl/spi_flash_command_planner.sv
// Serial NOR flash command planner.
// The req channel takes one request beat: kind, 24-bit address and length. The txn
// channel gives the flash transactions for it, one beat each, the final one with last.
// A read gives one beat, an erase two. A write is cut at page boundaries and the top
// of the address space; each chunk gives a write-enable beat and a page program beat.
// Writes longer than MAX_WRITE_BYTES are cut to it and flagged clamped.
// Unknown kinds and empty writes give no beat.
// req.ready is high only while the block is idle; one request is handled at a time.
// A read or erase beat appears in the cycle after the request is taken.
// A write first finds the page offset of its address with a remainder unit that
// multiplies by the reciprocal of the page size and corrects once, in quotient, trial
// and fix steps, then sizes each chunk in the S_REM state before that chunk's beats.
// Each transaction beat holds on txn until it is taken; a stalled receiver simply
// stretches the sequence. After the last beat is taken, req.ready returns next cycle.
// Reset returns the block to idle with no beat pending.
module spi_flash_command_planner #(
    parameter int PAGE_BYTES = sfcp_pkg::PAGE_BYTES_DEF,
    parameter int MAX_WRITE_BYTES = sfcp_pkg::MAX_WRITE_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    sfcp_req_if.sink      req,
    sfcp_txn_if.source    txn
);

    localparam int REM_W = $clog2(PAGE_BYTES);
    localparam int CHUNK_W = $clog2(PAGE_BYTES + 1);
    localparam int TOP_W = sfcp_pkg::ADDR_W + 1;

    sfcp_pkg::state_t                  state_reg;
    sfcp_pkg::state_t                  state_next;
    logic [sfcp_pkg::KIND_W-1:0]       kind_reg;
    logic [sfcp_pkg::KIND_W-1:0]       kind_next;
    logic [sfcp_pkg::ADDR_W-1:0]       cur_reg;
    logic [sfcp_pkg::ADDR_W-1:0]       cur_next;
    logic [sfcp_pkg::LEN_W-1:0]        len_reg;
    logic [sfcp_pkg::LEN_W-1:0]        len_next;
    logic                              clamp_reg;
    logic                              clamp_next;
    logic                              first_reg;
    logic                              first_next;
    logic [CHUNK_W-1:0]                chunk_reg;
    logic [CHUNK_W-1:0]                chunk_next;
    logic [sfcp_pkg::CNT_W-1:0]        cnt_reg;
    logic [sfcp_pkg::CNT_W-1:0]        cnt_next;

    logic                              rem_start;
    logic                              rem_busy;
    logic [REM_W-1:0]                  rem;
    logic [CHUNK_W-1:0]                room;
    logic [TOP_W-1:0]                  top_space;
    logic [CHUNK_W-1:0]                chunk_calc;
    logic                              prog_last;
    logic                              req_fire;
    logic                              txn_fire;

    sfcp_rem_unit #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (req.address),
        .busy     (rem_busy),
        .rem      (rem)
    );

    assign req.ready = (state_reg == sfcp_pkg::S_IDLE);
    assign req_fire = req.valid && req.ready;
    assign txn_fire = txn.valid && txn.ready;

    assign rem_start = req_fire && (req.kind == sfcp_pkg::KIND_WRITE) && (req.length != '0);

    // Only the first chunk of a write can start inside a page.
    always_comb
    begin
        if (first_reg)
        begin
            room = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(rem);
        end
        else
        begin
            room = CHUNK_W'(PAGE_BYTES);
        end
        top_space = {1'b1, {sfcp_pkg::ADDR_W{1'b0}}} - {1'b0, cur_reg};
        chunk_calc = room;
        if (len_reg < sfcp_pkg::LEN_W'(room))
        begin
            chunk_calc = CHUNK_W'(len_reg);
        end
        if (TOP_W'(chunk_calc) > top_space)
        begin
            chunk_calc = CHUNK_W'(top_space);
        end
    end

    assign prog_last = (len_reg == sfcp_pkg::LEN_W'(chunk_reg))
                       || (cnt_reg == sfcp_pkg::CNT_W'(sfcp_pkg::MAX_CHUNKS - 1));

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        cur_next = cur_reg;
        len_next = len_reg;
        clamp_next = clamp_reg;
        first_next = first_reg;
        chunk_next = chunk_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            sfcp_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    kind_next = req.kind;
                    cur_next = req.address;
                    len_next = req.length;
                    clamp_next = 1'b0;
                    first_next = 1'b1;
                    cnt_next = '0;
                    case (req.kind)
                        sfcp_pkg::KIND_READ:
                        begin
                            state_next = sfcp_pkg::S_READ;
                        end
                        sfcp_pkg::KIND_WRITE:
                        begin
                            if (req.length > sfcp_pkg::LEN_W'(MAX_WRITE_BYTES))
                            begin
                                len_next = sfcp_pkg::LEN_W'(MAX_WRITE_BYTES);
                                clamp_next = 1'b1;
                            end
                            if (req.length != '0)
                            begin
                                state_next = sfcp_pkg::S_REM;
                            end
                        end
                        sfcp_pkg::KIND_SECTOR, sfcp_pkg::KIND_BLOCK, sfcp_pkg::KIND_CHIP:
                        begin
                            state_next = sfcp_pkg::S_EWREN;
                        end
                        default:
                        begin
                            state_next = sfcp_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            sfcp_pkg::S_READ:
            begin
                if (txn_fire)
                begin
                    state_next = sfcp_pkg::S_IDLE;
                end
            end
            sfcp_pkg::S_EWREN:
            begin
                if (txn_fire)
                begin
                    state_next = sfcp_pkg::S_ERASE;
                end
            end
            sfcp_pkg::S_ERASE:
            begin
                if (txn_fire)
                begin
                    state_next = sfcp_pkg::S_IDLE;
                end
            end
            sfcp_pkg::S_REM:
            begin
                if (!rem_busy)
                begin
                    chunk_next = chunk_calc;
                    state_next = sfcp_pkg::S_WREN;
                end
            end
            sfcp_pkg::S_WREN:
            begin
                if (txn_fire)
                begin
                    state_next = sfcp_pkg::S_PROG;
                end
            end
            sfcp_pkg::S_PROG:
            begin
                if (txn_fire)
                begin
                    len_next = len_reg - sfcp_pkg::LEN_W'(chunk_reg);
                    cur_next = cur_reg + sfcp_pkg::ADDR_W'(chunk_reg);
                    first_next = 1'b0;
                    cnt_next = cnt_reg + sfcp_pkg::CNT_W'(1);
                    if (prog_last)
                    begin
                        state_next = sfcp_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = sfcp_pkg::S_REM;
                    end
                end
            end
            default:
            begin
                state_next = sfcp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfcp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        cur_reg <= cur_next;
        len_reg <= len_next;
        clamp_reg <= clamp_next;
        first_reg <= first_next;
        chunk_reg <= chunk_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        txn.valid = 1'b0;
        txn.opcode = sfcp_pkg::OP_WREN;
        txn.flash_address = '0;
        txn.has_address = 1'b0;
        txn.data_dir = sfcp_pkg::DIR_NONE;
        txn.data_count = '0;
        txn.poll_after = 1'b0;
        txn.clamped = 1'b0;
        txn.last = 1'b0;
        case (state_reg)
            sfcp_pkg::S_READ:
            begin
                txn.valid = 1'b1;
                txn.opcode = sfcp_pkg::OP_READ;
                txn.flash_address = cur_reg;
                txn.has_address = 1'b1;
                txn.data_dir = sfcp_pkg::DIR_RECV;
                txn.data_count = len_reg;
                txn.last = 1'b1;
            end
            sfcp_pkg::S_EWREN:
            begin
                txn.valid = 1'b1;
                txn.poll_after = (kind_reg != sfcp_pkg::KIND_CHIP);
            end
            sfcp_pkg::S_ERASE:
            begin
                txn.valid = 1'b1;
                txn.poll_after = 1'b1;
                txn.last = 1'b1;
                case (kind_reg)
                    sfcp_pkg::KIND_SECTOR:
                    begin
                        txn.opcode = sfcp_pkg::OP_SECTOR;
                        txn.flash_address = cur_reg;
                        txn.has_address = 1'b1;
                    end
                    sfcp_pkg::KIND_BLOCK:
                    begin
                        txn.opcode = sfcp_pkg::OP_BLOCK;
                        txn.flash_address = cur_reg;
                        txn.has_address = 1'b1;
                    end
                    default:
                    begin
                        txn.opcode = sfcp_pkg::OP_CHIP;
                    end
                endcase
            end
            sfcp_pkg::S_WREN:
            begin
                txn.valid = 1'b1;
                txn.clamped = clamp_reg;
            end
            sfcp_pkg::S_PROG:
            begin
                txn.valid = 1'b1;
                txn.opcode = sfcp_pkg::OP_PROGRAM;
                txn.flash_address = cur_reg;
                txn.has_address = 1'b1;
                txn.data_dir = sfcp_pkg::DIR_SEND;
                txn.data_count = sfcp_pkg::LEN_W'(chunk_reg);
                txn.poll_after = 1'b1;
                txn.clamped = clamp_reg;
                txn.last = prog_last;
            end
            default:
            begin
                txn.valid = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/sfcp_checker.sv
module sfcp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_ready,
    input  logic                                txn_valid,
    input  logic                                txn_ready,
    input  logic [sfcp_pkg::OPCODE_W-1:0]       txn_opcode,
    input  logic                                txn_has_address,
    input  logic [sfcp_pkg::LEN_W-1:0]          txn_data_count,
    input  logic                                txn_poll_after,
    input  logic                                txn_last
);

    // A pending beat stays until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        txn_valid && !txn_ready |=> txn_valid)
        else $error("txn beat dropped while stalled");

    // Requests are taken only while no transaction is on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !txn_valid)
        else $error("request accepted while a transaction is pending");

    // The block returns to idle right after the final beat of a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        txn_valid && txn_ready && txn_last |=> req_ready)
        else $error("block not idle after final beat");

    // A page program always carries an address, data and a poll.
    assert property (@(posedge clk) disable iff (!rst_n)
        txn_valid && (txn_opcode == sfcp_pkg::OP_PROGRAM)
        |-> txn_has_address && txn_poll_after && (txn_data_count != '0))
        else $error("malformed page program");

    // A write-enable never ends a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        txn_valid && (txn_opcode == sfcp_pkg::OP_WREN) |-> !txn_last)
        else $error("write-enable marked as final beat");

endmodule

bind spi_flash_command_planner sfcp_checker u_sfcp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .txn_valid       (txn.valid),
    .txn_ready       (txn.ready),
    .txn_opcode      (txn.opcode),
    .txn_has_address (txn.has_address),
    .txn_data_count  (txn.data_count),
    .txn_poll_after  (txn.poll_after),
    .txn_last        (txn.last)
);

>>> sim/spi_flash_command_planner_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic [sfcp_pkg::OPCODE_W-1:0] opcode;
    logic [sfcp_pkg::ADDR_W-1:0]   flash_address;
    logic                          has_address;
    logic [sfcp_pkg::DIR_W-1:0]    data_dir;
    logic [sfcp_pkg::LEN_W-1:0]    data_count;
    logic                          poll_after;
    logic                          clamped;
    logic                          last;
} flash_txn_t;

class txn_scoreboard;
    flash_txn_t  planned_txns[$];
    int          failures;
    int          checked;
    int          requests_by_kind[8];

    function void add_txn(logic [sfcp_pkg::OPCODE_W-1:0] op,
                          logic [sfcp_pkg::ADDR_W-1:0] addr, logic has_addr,
                          logic [sfcp_pkg::DIR_W-1:0] dir,
                          logic [sfcp_pkg::LEN_W-1:0] count, logic poll, logic clamp);
        flash_txn_t t;
        t.opcode = op;
        t.flash_address = addr;
        t.has_address = has_addr;
        t.data_dir = dir;
        t.data_count = count;
        t.poll_after = poll;
        t.clamped = clamp;
        t.last = 1'b0;
        planned_txns.push_back(t);
    endfunction

    function void note_request(logic [sfcp_pkg::KIND_W-1:0] kind,
                               logic [sfcp_pkg::ADDR_W-1:0] address,
                               logic [sfcp_pkg::LEN_W-1:0] length);
        int unsigned left;
        int unsigned cur;
        int unsigned room;
        int unsigned top;
        int unsigned chunk;
        int          queued_prior;
        int          produced;
        logic        clamp;
        queued_prior = planned_txns.size();
        produced = 0;
        requests_by_kind[kind]++;
        case (kind)
            sfcp_pkg::KIND_READ:
                add_txn(sfcp_pkg::OP_READ, address, 1'b1, sfcp_pkg::DIR_RECV, length,
                        1'b0, 1'b0);
            sfcp_pkg::KIND_WRITE:
            begin
                left = 32'(length);
                clamp = 1'b0;
                cur = 32'(address);
                if (left > sfcp_pkg::MAX_WRITE_BYTES_DEF)
                begin
                    left = sfcp_pkg::MAX_WRITE_BYTES_DEF;
                    clamp = 1'b1;
                end
                while (left > 0 && produced + 2 <= sfcp_pkg::MAX_RESULTS)
                begin
                    room = sfcp_pkg::PAGE_BYTES_DEF - (cur % sfcp_pkg::PAGE_BYTES_DEF);
                    top = (32'd1 << sfcp_pkg::ADDR_W) - cur;
                    chunk = left;
                    if (chunk > room)
                        chunk = room;
                    if (chunk > top)
                        chunk = top;
                    add_txn(sfcp_pkg::OP_WREN, '0, 1'b0, sfcp_pkg::DIR_NONE, '0, 1'b0, clamp);
                    add_txn(sfcp_pkg::OP_PROGRAM, cur[sfcp_pkg::ADDR_W-1:0], 1'b1,
                            sfcp_pkg::DIR_SEND, chunk[sfcp_pkg::LEN_W-1:0], 1'b1, clamp);
                    produced += 2;
                    left -= chunk;
                    cur = (cur + chunk) & ((32'd1 << sfcp_pkg::ADDR_W) - 1);
                end
            end
            sfcp_pkg::KIND_SECTOR, sfcp_pkg::KIND_BLOCK:
            begin
                add_txn(sfcp_pkg::OP_WREN, '0, 1'b0, sfcp_pkg::DIR_NONE, '0, 1'b1, 1'b0);
                add_txn((kind == sfcp_pkg::KIND_SECTOR) ? sfcp_pkg::OP_SECTOR
                                                        : sfcp_pkg::OP_BLOCK,
                        address, 1'b1, sfcp_pkg::DIR_NONE, '0, 1'b1, 1'b0);
            end
            sfcp_pkg::KIND_CHIP:
            begin
                add_txn(sfcp_pkg::OP_WREN, '0, 1'b0, sfcp_pkg::DIR_NONE, '0, 1'b0, 1'b0);
                add_txn(sfcp_pkg::OP_CHIP, '0, 1'b0, sfcp_pkg::DIR_NONE, '0, 1'b1, 1'b0);
            end
            default:
            begin
            end
        endcase
        if (planned_txns.size() > queued_prior)
            planned_txns[planned_txns.size() - 1].last = 1'b1;
    endfunction

    function string describe(flash_txn_t t);
        return $sformatf({"op=%h addr=%h has_addr=%b dir=%0d count=%0d poll=%b ",
                          "clamped=%b last=%b"},
                         t.opcode, t.flash_address, t.has_address, t.data_dir, t.data_count,
                         t.poll_after, t.clamped, t.last);
    endfunction

    function void check_txn(flash_txn_t got);
        flash_txn_t want;
        checked++;
        if (planned_txns.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("Unexpected beat: %s", describe(got));
        end
        else
        begin
            want = planned_txns.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("Mismatch on beat %0d:", checked);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        end
    endfunction
endclass

module spi_flash_command_planner_tb;

    localparam int QUIET_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 100;
    localparam logic [sfcp_pkg::KIND_W-1:0] KIND_RESERVED_LO = 3'd5;
    localparam logic [sfcp_pkg::KIND_W-1:0] KIND_RESERVED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    bit   idling_on = 1'b1;
    int   quiet_cycles = 0;

    txn_scoreboard board = new();

    sfcp_req_if req();
    sfcp_txn_if txn();

    spi_flash_command_planner #(
        .PAGE_BYTES(sfcp_pkg::PAGE_BYTES_DEF),
        .MAX_WRITE_BYTES(sfcp_pkg::MAX_WRITE_BYTES_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .txn(txn)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        flash_txn_t seen;
        if (rst_n === 1'b1)
        begin
            if (req.valid && req.ready)
                board.note_request(req.kind, req.address, req.length);
            if (txn.valid && txn.ready)
            begin
                seen.opcode = txn.opcode;
                seen.flash_address = txn.flash_address;
                seen.has_address = txn.has_address;
                seen.data_dir = txn.data_dir;
                seen.data_count = txn.data_count;
                seen.poll_after = txn.poll_after;
                seen.clamped = txn.clamped;
                seen.last = txn.last;
                board.check_txn(seen);
            end
            if ((req.valid && req.ready) || (txn.valid && txn.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog expired with %0d beats outstanding.",
                         board.planned_txns.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // The receiver stalls in short bursts and once holds off long enough to back up requests.
    initial
    begin
        int stall_left;
        bit long_hold_done;
        stall_left = 0;
        long_hold_done = 1'b0;
        txn.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && board.checked >= 40)
            begin
                long_hold_done = 1'b1;
                stall_left = 400;
            end
            else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13);
            end
            if (stall_left > 0)
            begin
                txn.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                txn.ready <= 1'b1;
            end
        end
    end

    task automatic send_request(logic [sfcp_pkg::KIND_W-1:0] kind,
                                logic [sfcp_pkg::ADDR_W-1:0] address,
                                logic [sfcp_pkg::LEN_W-1:0] length);
        req.valid <= 1'b1;
        req.kind <= kind;
        req.address <= address;
        req.length <= length;
        do
            @(posedge clk);
        while (!req.ready);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic pick_request(output logic [sfcp_pkg::KIND_W-1:0] kind,
                                output logic [sfcp_pkg::ADDR_W-1:0] address,
                                output logic [sfcp_pkg::LEN_W-1:0] length);
        int unsigned sel;
        int unsigned a;
        sel = $urandom_range(0, 99);
        if (sel < 20)
            kind = sfcp_pkg::KIND_READ;
        else if (sel < 60)
            kind = sfcp_pkg::KIND_WRITE;
        else if (sel < 72)
            kind = sfcp_pkg::KIND_SECTOR;
        else if (sel < 82)
            kind = sfcp_pkg::KIND_BLOCK;
        else if (sel < 90)
            kind = sfcp_pkg::KIND_CHIP;
        else
            kind = sfcp_pkg::KIND_W'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI));

        a = $urandom() & ((32'd1 << sfcp_pkg::ADDR_W) - 1);
        case ($urandom_range(0, 3))
            0: ;
            1: a = a - (a % sfcp_pkg::PAGE_BYTES_DEF) + sfcp_pkg::PAGE_BYTES_DEF - 1
                   - $urandom_range(0, 15);
            2: a = ((32'd1 << sfcp_pkg::ADDR_W) - 1) - $urandom_range(0, 600);
            default: a = a - (a % sfcp_pkg::PAGE_BYTES_DEF);
        endcase
        address = a[sfcp_pkg::ADDR_W-1:0];

        // Most writes stay short so the run is not dominated by long page sequences.
        sel = $urandom_range(0, 19);
        if (kind != sfcp_pkg::KIND_WRITE || sel == 0)
            length = sfcp_pkg::LEN_W'($urandom_range(0, 65535));
        else if (sel == 1)
            length = sfcp_pkg::LEN_W'(sfcp_pkg::MAX_WRITE_BYTES_DEF - 2
                                      + $urandom_range(0, 4));
        else
            length = sfcp_pkg::LEN_W'($urandom_range(1, 700));
    endtask

    initial
    begin
        logic [sfcp_pkg::KIND_W-1:0] kind;
        logic [sfcp_pkg::ADDR_W-1:0] address;
        logic [sfcp_pkg::LEN_W-1:0]  length;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.kind <= sfcp_pkg::KIND_READ;
        req.address <= '0;
        req.length <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(sfcp_pkg::KIND_READ, 24'h000000, 16'h0000);
        send_request(sfcp_pkg::KIND_READ, 24'hFFFFFF, 16'hFFFF);
        send_request(sfcp_pkg::KIND_WRITE, 24'h000000, 16'h0000);
        send_request(sfcp_pkg::KIND_WRITE, 24'h000100, 16'd256);
        send_request(sfcp_pkg::KIND_WRITE, 24'h0000FF, 16'd2);
        send_request(sfcp_pkg::KIND_WRITE, 24'hFFFFFF, 16'd2);
        send_request(sfcp_pkg::KIND_WRITE, 24'h123400, 16'd4096);
        send_request(sfcp_pkg::KIND_WRITE, 24'h1234F0, 16'd4096);
        send_request(sfcp_pkg::KIND_WRITE, 24'hABCDEF, 16'hFFFF);
        send_request(sfcp_pkg::KIND_WRITE, 24'h000000, 16'd4097);
        send_request(sfcp_pkg::KIND_WRITE, 24'hFFFF00, 16'd4096);
        send_request(sfcp_pkg::KIND_WRITE, 24'h7FFFFF, 16'd1);
        send_request(sfcp_pkg::KIND_SECTOR, 24'h000000, 16'h0000);
        send_request(sfcp_pkg::KIND_SECTOR, 24'hFFFFFF, 16'hFFFF);
        send_request(sfcp_pkg::KIND_BLOCK, 24'h555555, 16'hAAAA);
        send_request(sfcp_pkg::KIND_BLOCK, 24'hAAAAAA, 16'h5555);
        send_request(sfcp_pkg::KIND_CHIP, 24'h000000, 16'h0000);
        send_request(sfcp_pkg::KIND_CHIP, 24'hFFFFFF, 16'hFFFF);
        send_request(KIND_RESERVED_LO, 24'hFFFFFF, 16'hFFFF);
        send_request(KIND_RESERVED_LO + 3'd1, 24'h5A5A5A, 16'h1234);
        send_request(KIND_RESERVED_HI, 24'h000000, 16'h0000);
        send_request(sfcp_pkg::KIND_READ, 24'h5A5A5A, 16'h0001);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 20)
                idling_on = 1'b0;
            if (i == 50)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
                while (board.planned_txns.size() != 0)
                    @(posedge clk);
            end
            pick_request(kind, address, length);
            send_request(kind, address, length);
        end

        req.valid <= 1'b0;
        @(posedge clk);
        while (board.planned_txns.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Sent %0d reads, %0d writes, %0d sector, %0d block, %0d chip erases and %0d",
                 board.requests_by_kind[sfcp_pkg::KIND_READ],
                 board.requests_by_kind[sfcp_pkg::KIND_WRITE],
                 board.requests_by_kind[sfcp_pkg::KIND_SECTOR],
                 board.requests_by_kind[sfcp_pkg::KIND_BLOCK],
                 board.requests_by_kind[sfcp_pkg::KIND_CHIP],
                 board.requests_by_kind[5] + board.requests_by_kind[6] +
                 board.requests_by_kind[7]);
        $display("reserved requests; checked %0d transaction beats, %0d failures.",
                 board.checked, board.failures);
        if (board.failures == 0 && board.planned_txns.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
